FILE: hw/rtl/spq_pkg.sv
// Shared constants and types for the sorted priority queue.
package spq_pkg;
	localparam int DEPTH      = 16;
	localparam int VALUE_BITS = 16;
	localparam int RANK_BITS  = 8;
	localparam int CNT_BITS   = $clog2(DEPTH + 1);
	localparam int FILL_BITS  = 5;
	localparam int STAT_BITS  = 2;

	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	localparam logic [STAT_BITS-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_BITS-1:0] ST_UNDER = 2'd1;
	localparam logic [STAT_BITS-1:0] ST_OVER  = 2'd2;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] value;
		logic [RANK_BITS-1:0]         rank;
	} entry_t;

	typedef struct packed {
		logic   push;
		logic   pop;
		entry_t item;
	} cell_ctl_t;
endpackage

FILE: hw/rtl/spq_cell.sv
// One slot of the sorted chain: holds an entry, shifts toward head or tail.
module spq_cell import spq_pkg::*; (
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  logic      head,
	input  logic      occ,
	input  logic      head_flag,
	input  logic      flag_prev,
	input  entry_t    left_ent,
	input  entry_t    right_ent,
	output logic      flag,
	output entry_t    ent
);
	entry_t ent_q;

	// flag: the insert position is at or before this slot
	always_comb begin
		if (head) begin
			flag = !occ || (ctl.item.rank >= ent_q.rank);
		end else begin
			flag = head_flag || !occ || (ctl.item.rank > ent_q.rank);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			ent_q <= right_ent;
		end else if (ctl.push && flag) begin
			ent_q <= flag_prev ? left_ent : ctl.item;
		end
	end

	assign ent = ent_q;
endmodule

FILE: hw/rtl/sorted_priority_queue_unit.sv
// Sorted priority queue top level: cell chain, entry count and result register.
//
//  channel | signals                                     | role
//  in      | in_valid, in_ready, command, item_value,    | enqueue / dequeue command
//          | item_rank                                   |
//  out     | out_valid, out_ready, status, head_value,   | one result per command
//          | head_rank, fill                             |
//
// The result of each command appears in the output register the
// cycle after the transfer. All slots compare against the new rank in parallel
// and shift one place in the same cycle, so a new command is taken every cycle
// while the output register is empty or being drained.
// Reset clears the entry count and the output valid; slot contents need none.
// A stalled result holds in_ready low until it is taken.
module sorted_priority_queue_unit import spq_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         command,
	input  logic signed [VALUE_BITS-1:0] item_value,
	input  logic [RANK_BITS-1:0]         item_rank,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [STAT_BITS-1:0]         status,
	output logic signed [VALUE_BITS-1:0] head_value,
	output logic [RANK_BITS-1:0]         head_rank,
	output logic [FILL_BITS-1:0]         fill
);
	logic [CNT_BITS-1:0]          count_q;
	logic                         out_valid_q;
	logic [STAT_BITS-1:0]         status_q;
	logic signed [VALUE_BITS-1:0] head_value_q;
	logic [RANK_BITS-1:0]         head_rank_q;

	logic      xfer, is_full, is_empty;
	cell_ctl_t ctl;
	logic      [DEPTH-1:0] occ;
	logic      [DEPTH-1:0] flag;
	entry_t    ent [DEPTH];

	assign in_ready = !out_valid_q || out_ready;
	assign xfer     = in_valid && in_ready;
	assign is_full  = (count_q == CNT_BITS'(DEPTH));
	assign is_empty = (count_q == '0);

	assign ctl.push       = xfer && (command == CMD_ENQ) && !is_full;
	assign ctl.pop        = xfer && (command == CMD_DEQ) && !is_empty;
	assign ctl.item.value = item_value;
	assign ctl.item.rank  = item_rank;

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		assign occ[g] = count_q > CNT_BITS'(g);
		spq_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.head      (g == 0),
			.occ       (occ[g]),
			.head_flag (flag[0]),
			.flag_prev ((g == 0) ? 1'b0 : flag[(g == 0) ? 0 : g - 1]),
			.left_ent  ((g == 0) ? ctl.item : ent[(g == 0) ? 0 : g - 1]),
			.right_ent ((g == DEPTH - 1) ? ctl.item : ent[(g == DEPTH - 1) ? g : g + 1]),
			.flag      (flag[g]),
			.ent       (ent[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.push) begin
				count_q <= count_q + CNT_BITS'(1);
			end else if (ctl.pop) begin
				count_q <= count_q - CNT_BITS'(1);
			end
			if (xfer) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			if (ctl.pop) begin
				status_q     <= ST_OK;
				head_value_q <= ent[0].value;
				head_rank_q  <= ent[0].rank;
			end else begin
				if (command == CMD_DEQ) begin
					status_q <= ST_UNDER;
				end else if (is_full) begin
					status_q <= ST_OVER;
				end else begin
					status_q <= ST_OK;
				end
				head_value_q <= '0;
				head_rank_q  <= '0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign head_value = head_value_q;
	assign head_rank  = head_rank_q;
	assign fill       = FILL_BITS'(count_q);

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(DEPTH))
		else $error("entry count above depth");

	a_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && (command == CMD_ENQ) && is_full |=> (status == ST_OVER) && out_valid)
		else $error("full enqueue did not report overflow");

	a_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && (command == CMD_DEQ) && is_empty |=> (status == ST_UNDER) && (count_q == '0))
		else $error("empty dequeue did not report underflow");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |=> count_q == $past(count_q) - CNT_BITS'(1))
		else $error("dequeue did not decrement count");
`endif
endmodule

FILE: dv/sorted_priority_queue_unit_tb.sv
// Self-checking testbench for the sorted priority queue unit.
module sorted_priority_queue_unit_tb;
	import spq_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [STAT_BITS-1:0]         status;
		logic signed [VALUE_BITS-1:0] value;
		logic [RANK_BITS-1:0]         rank;
		logic [FILL_BITS-1:0]         fill;
	} outcome_t;

	class queue_scoreboard;
		entry_t   held[$];
		outcome_t due[$];
		bit       failed;

		function void note_command(logic cmd, entry_t e);
			outcome_t o;
			entry_t   h;
			int       pos;
			o = '0;
			if (cmd == CMD_DEQ) begin
				if (held.size() == 0) begin
					o.status = ST_UNDER;
				end else begin
					h = held.pop_front();
					o.status = ST_OK;
					o.value = h.value;
					o.rank = h.rank;
				end
			end else if (held.size() >= DEPTH) begin
				o.status = ST_OVER;
			end else begin
				pos = held.size();
				if (held.size() == 0 || held[0].rank <= e.rank) begin
					pos = 0;
				end else begin
					for (int i = 1; i < held.size(); i++) begin
						if (e.rank > held[i].rank) begin
							pos = i;
							break;
						end
					end
				end
				held.insert(pos, e);
				o.status = ST_OK;
			end
			o.fill = FILL_BITS'(held.size());
			due.push_back(o);
		endfunction

		function void check_result(outcome_t got);
			outcome_t exp;
			if (due.size() == 0) begin
				$error("result transfer with nothing expected");
				failed = 1'b1;
				return;
			end
			exp = due.pop_front();
			if (got.status !== exp.status) begin
				$error("status: expected %0d, got %0d", exp.status, got.status);
				failed = 1'b1;
			end
			if (got.value !== exp.value) begin
				$error("head_value: expected %0d, got %0d", exp.value, got.value);
				failed = 1'b1;
			end
			if (got.rank !== exp.rank) begin
				$error("head_rank: expected %0d, got %0d", exp.rank, got.rank);
				failed = 1'b1;
			end
			if (got.fill !== exp.fill) begin
				$error("fill: expected %0d, got %0d", exp.fill, got.fill);
				failed = 1'b1;
			end
		endfunction
	endclass

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_ready;
	logic                         command;
	logic signed [VALUE_BITS-1:0] item_value;
	logic [RANK_BITS-1:0]         item_rank;
	logic                         out_valid;
	logic                         out_ready;
	logic [STAT_BITS-1:0]         status;
	logic signed [VALUE_BITS-1:0] head_value;
	logic [RANK_BITS-1:0]         head_rank;
	logic [FILL_BITS-1:0]         fill;

	queue_scoreboard sb = new;
	int unsigned     src_idle_pct = 0;
	int unsigned     sink_stall_pct = 0;
	int unsigned     hold_left = 0;
	int unsigned     cycle_count = 0;

	sorted_priority_queue_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.item_value (item_value),
		.item_rank  (item_rank),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.head_value (head_value),
		.head_rank  (head_rank),
		.fill       (fill)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// result side; a pending hold-off overrides the random stall
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_result(outcome_t'{status, head_value, head_rank, fill});
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	// valid stays high across back-to-back transfers
	task automatic offer(input logic cmd, input logic signed [VALUE_BITS-1:0] v,
			input logic [RANK_BITS-1:0] r);
		entry_t e;
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		e.value = v;
		e.rank = r;
		in_valid <= 1'b1;
		command <= cmd;
		item_value <= v;
		item_rank <= r;
		do @(posedge clk); while (!in_ready);
		sb.note_command(cmd, e);
	endtask

	task automatic random_run(input int count);
		int unsigned          enq_pct;
		logic                 cmd;
		logic [RANK_BITS-1:0] r;
		enq_pct = 50;
		for (int n = 0; n < count; n++) begin
			// pick drain-heavy, balanced or fill-heavy stretches at random to hit full and empty
			if (n % 40 == 0) begin
				case ($urandom_range(2))
					0: enq_pct = 20;
					1: enq_pct = 50;
					default: enq_pct = 85;
				endcase
			end
			cmd = ($urandom_range(99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
			case ($urandom_range(2))
				0: r = RANK_BITS'($urandom_range(3));
				1: r = RANK_BITS'($urandom_range(255, 252));
				default: r = RANK_BITS'($urandom);
			endcase
			offer(cmd, VALUE_BITS'($urandom), r);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		command <= CMD_ENQ;
		item_value <= '0;
		item_rank <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty dequeue, field extremes, head tie, tie behind head, fill and overflow
		offer(CMD_DEQ, 16'sh1234, 8'd7);
		offer(CMD_ENQ, 16'sh7fff, 8'd0);
		offer(CMD_ENQ, 16'sh8000, 8'd255);
		offer(CMD_ENQ, 16'sh0000, 8'd255);
		offer(CMD_ENQ, 16'sh0001, 8'd0);
		offer(CMD_ENQ, 16'shffff, 8'd128);
		for (int k = 0; k < 11; k++)
			offer(CMD_ENQ, VALUE_BITS'(k * 4099 - 20000), RANK_BITS'(k * 53));
		offer(CMD_ENQ, 16'sh0005, 8'd9);
		for (int k = 0; k < 3; k++)
			offer(CMD_DEQ, VALUE_BITS'($urandom), RANK_BITS'($urandom));

		// long receiver hold-off so the input stalls behind a full result register
		hold_left = 60;
		random_run(25);

		random_run(300);
		src_idle_pct = 74;
		random_run(300);
		src_idle_pct = 0;
		sink_stall_pct = 74;
		random_run(300);
		src_idle_pct = 6;
		sink_stall_pct = 6;
		random_run(300);
		in_valid <= 1'b0;
		src_idle_pct = 0;
		sink_stall_pct = 0;

		while (sb.due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (!sb.failed)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
